@@ rtl/core/jbl_pkg.sv @@
package jbl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_LITERAL = 3'd3,
        MODE_ERROR   = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        KIND_LBRACE   = 4'd0,
        KIND_RBRACE   = 4'd1,
        KIND_LBRACKET = 4'd2,
        KIND_RBRACKET = 4'd3,
        KIND_COMMA    = 4'd4,
        KIND_COLON    = 4'd5,
        KIND_STRING   = 4'd6,
        KIND_NUMBER   = 4'd7,
        KIND_NULL     = 4'd8,
        KIND_BOOL     = 4'd9,
        KIND_ERROR    = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_START = 2'd1,
        ERR_CHAR  = 2'd2,
        ERR_END   = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        LIT_NULL  = 2'd0,
        LIT_TRUE  = 2'd1,
        LIT_FALSE = 2'd2
    } lit_t;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       has;
        logic       last;
        err_t       err;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_t;

    typedef struct packed {
        logic    emit;
        result_t res;
        mode_t   mode;
        logic    lit_load;
        lit_t    sel;
    } start_t;

    function automatic result_t make_result(kind_t kind, logic [7:0] value, logic has,
                                            logic last, err_t err);
        result_t r;
        r.kind  = kind;
        r.value = has ? value : 8'd0;
        r.has   = has;
        r.last  = last;
        r.err   = err;
        return r;
    endfunction

    function automatic logic [2:0] lit_len(lit_t sel);
        return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic kind_t lit_kind(lit_t sel);
        kind_t k;
        case (sel)
            LIT_TRUE, LIT_FALSE: k = KIND_BOOL;
            default:             k = KIND_NULL;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] lit_char(lit_t sel, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            LIT_TRUE:
                case (pos)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            LIT_FALSE:
                case (pos)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = 8'h00;
                endcase
            default:
                case (pos)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = 8'h00;
                endcase
        endcase
        return ch;
    endfunction

    function automatic logic is_number_char(logic [7:0] c);
        return (c == CH_MINUS) || (c == CH_DOT) || ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    // Decode a byte seen between tokens.
    function automatic start_t start_token(logic [7:0] c);
        start_t s;
        s.emit     = 1'b0;
        s.res      = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_NONE);
        s.mode     = MODE_IDLE;
        s.lit_load = 1'b0;
        s.sel      = LIT_NULL;
        case (c) inside
            CH_SPACE, CH_NEWLINE: ;
            CH_LBRACE: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_LBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_RBRACE: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_RBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_LBRACKET: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_LBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_RBRACKET: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_RBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_COMMA: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_COMMA, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_COLON: begin
                s.emit = 1'b1;
                s.res  = make_result(KIND_COLON, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end
            CH_QUOTE: begin
                s.mode = MODE_STRING;
            end
            CH_N, CH_T, CH_F: begin
                s.sel      = (c == CH_N) ? LIT_NULL : ((c == CH_T) ? LIT_TRUE : LIT_FALSE);
                s.lit_load = 1'b1;
                s.mode     = MODE_LITERAL;
                s.emit     = 1'b1;
                s.res      = make_result(lit_kind(s.sel), c, 1'b1, 1'b0, ERR_NONE);
            end
            CH_MINUS, [CH_ZERO:CH_NINE]: begin
                s.mode = MODE_NUMBER;
                s.emit = 1'b1;
                s.res  = make_result(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
            end
            default: begin
                s.mode = MODE_ERROR;
                s.emit = 1'b1;
                s.res  = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_START);
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/jbl_lexer.sv @@
module jbl_lexer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     char_byte,
    input  logic           end_of_input,
    output jbl_pkg::step_t step
);
    import jbl_pkg::*;

    mode_t      mode_reg, mode_next;
    lit_t       sel_reg, sel_next;
    logic [2:0] pos_reg, pos_next;

    start_t     st;
    logic [2:0] pos_inc;
    logic       mismatch;
    logic       lit_done;
    logic       num_more;

    assign st       = start_token(char_byte);
    assign pos_inc  = pos_reg + 3'd1;
    assign mismatch = (pos_reg >= lit_len(sel_reg)) || (char_byte != lit_char(sel_reg, pos_reg));
    assign lit_done = (pos_inc >= lit_len(sel_reg));
    assign num_more = !end_of_input && is_number_char(char_byte);

    always_comb
    begin
        mode_next = mode_reg;
        sel_next  = sel_reg;
        pos_next  = pos_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (!end_of_input)
                begin
                    mode_next = st.mode;
                    if (st.lit_load)
                    begin
                        sel_next = st.sel;
                        pos_next = 3'd1;
                    end
                end
            end
            MODE_STRING: begin
                if (end_of_input)
                    mode_next = MODE_ERROR;
                else if (char_byte == CH_QUOTE)
                    mode_next = MODE_IDLE;
            end
            MODE_NUMBER: begin
                if (!num_more)
                begin
                    // close the number, then treat the byte as a fresh token start
                    mode_next = MODE_IDLE;
                    if (!end_of_input)
                    begin
                        mode_next = st.mode;
                        if (st.lit_load)
                        begin
                            sel_next = st.sel;
                            pos_next = 3'd1;
                        end
                    end
                end
            end
            MODE_LITERAL: begin
                if (end_of_input || mismatch)
                    mode_next = MODE_ERROR;
                else if (lit_done)
                begin
                    mode_next = MODE_IDLE;
                    pos_next  = 3'd0;
                end
                else
                    pos_next = pos_inc;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        step.count  = 2'd0;
        step.first  = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_NONE);
        step.second = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b0, ERR_NONE);
        unique case (mode_reg)
            MODE_IDLE: begin
                if (!end_of_input && st.emit)
                begin
                    step.count = 2'd1;
                    step.first = st.res;
                end
            end
            MODE_STRING: begin
                step.count = 2'd1;
                if (end_of_input)
                    step.first = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_END);
                else if (char_byte == CH_QUOTE)
                    step.first = make_result(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
                else
                    step.first = make_result(KIND_STRING, char_byte, 1'b1, 1'b0, ERR_NONE);
            end
            MODE_NUMBER: begin
                if (num_more)
                begin
                    step.count = 2'd1;
                    step.first = make_result(KIND_NUMBER, char_byte, 1'b1, 1'b0, ERR_NONE);
                end
                else
                begin
                    step.first  = make_result(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    step.second = st.res;
                    step.count  = 2'd1 + {1'b0, (!end_of_input && st.emit)};
                end
            end
            MODE_LITERAL: begin
                step.count = 2'd1;
                if (end_of_input)
                    step.first = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_END);
                else if (mismatch)
                    step.first = make_result(KIND_ERROR, 8'd0, 1'b0, 1'b1, ERR_CHAR);
                else
                    step.first = make_result(lit_kind(sel_reg), char_byte, 1'b1, lit_done,
                                             ERR_NONE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            sel_reg  <= LIT_NULL;
            pos_reg  <= 3'd0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            sel_reg  <= sel_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

@@ rtl/core/jbl_obuf.sv @@
module jbl_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  jbl_pkg::step_t   step,
    output logic             take,
    output logic             token_valid,
    input  logic             token_stall,
    output jbl_pkg::result_t head
);
    import jbl_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign token_valid = (cnt_reg != 2'd0);
    assign head        = slot0_reg;
    assign pop         = token_valid && !token_stall;
    // take a new item only when everything before it has gone or leaves now
    assign take        = item_valid && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            slot0_next = step.first;
            slot1_next = step.second;
            cnt_next   = step.count;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ rtl/core/json_byte_lexer.sv @@
// channel | handshake                  | payload
// --------+----------------------------+------------------------------------------------
// byte    | byte_valid / byte_stall    | char_byte, end_of_input
// token   | token_valid / token_stall  | token_kind, value_byte, has_byte, token_end,
//         |                            | error_code
//
// One byte request per cycle while the result buffer has room. A byte passes the input
// register, then its first token is offered from the result buffer. A byte that closes a
// number and starts another token fills both slots; the next byte waits for the second to go.
// Reset puts the lexer between tokens and empties the input and result registers.
// token_stall reaches byte_stall in the same cycle through the result buffer's room.
module json_byte_lexer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_input,
    output logic       token_valid,
    input  logic       token_stall,
    output logic [3:0] token_kind,
    output logic [7:0] value_byte,
    output logic       has_byte,
    output logic       token_end,
    output logic [1:0] error_code
);
    import jbl_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] char_reg;
    logic       eoi_reg;
    logic       take;
    logic       accept;
    step_t      step;
    result_t    head;

    assign byte_stall = in_vld_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (take)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_byte;
            eoi_reg  <= end_of_input;
        end
    end

    jbl_lexer u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (take),
        .char_byte    (char_reg),
        .end_of_input (eoi_reg),
        .step         (step)
    );

    jbl_obuf u_obuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_vld_reg),
        .step        (step),
        .take        (take),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .head        (head)
    );

    assign token_kind = head.kind;
    assign value_byte = head.value;
    assign has_byte   = head.has;
    assign token_end  = head.last;
    assign error_code = head.err;

endmodule

@@ rtl/core/jbl_checker.sv @@
module jbl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic [7:0] char_byte,
    input logic       end_of_input,
    input logic       token_valid,
    input logic       token_stall,
    input logic [3:0] token_kind,
    input logic [7:0] value_byte,
    input logic       has_byte,
    input logic       token_end,
    input logic [1:0] error_code
);
    import jbl_pkg::*;

    logic err_tok;

    assign err_tok = token_valid && (token_kind == KIND_ERROR);

    // a stalled byte request holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_stall) |=> byte_valid && $stable(char_byte) && $stable(end_of_input))
        else $error("byte request changed while stalled");

    // an error closes its token and carries a reason
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        err_tok |-> token_end && (error_code != ERR_NONE))
        else $error("error token without end mark or code");

    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !err_tok) |-> (error_code == ERR_NONE))
        else $error("error code on a regular token");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !has_byte) |-> (value_byte == 8'd0))
        else $error("value byte not cleared");

    // errors are sticky: nothing follows a delivered error
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (err_tok && !token_stall) |=> !token_valid)
        else $error("token after error");

endmodule

bind json_byte_lexer jbl_checker u_jbl_checker (.*);

@@ dv/json_lexer_checker.sv @@
module json_lexer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_input,
    input  logic       token_valid,
    input  logic       token_stall,
    input  logic [3:0] token_kind,
    input  logic [7:0] value_byte,
    input  logic       has_byte,
    input  logic       token_end,
    input  logic [1:0] error_code,
    output int         fail_count,
    output int         pending,
    output int         tokens_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import jbl_pkg::*;

    // Shadow lexer state.
    mode_t      lex_mode;
    lit_t       lit_sel;
    logic [2:0] lit_pos;
    result_t    token_q[$];
    int         mismatches;
    int         checked;

    function automatic void push_token(kind_t k, logic [7:0] v, logic h, logic l, err_t e);
        result_t r;
        r.kind  = k;
        r.value = h ? v : 8'd0;
        r.has   = h;
        r.last  = l;
        r.err   = e;
        token_q.push_back(r);
    endfunction

    function automatic void lex_fail(err_t e);
        lex_mode = MODE_ERROR;
        push_token(KIND_ERROR, 8'd0, 1'b0, 1'b1, e);
    endfunction

    function automatic kind_t word_kind(lit_t s);
        return (s == LIT_TRUE || s == LIT_FALSE) ? KIND_BOOL : KIND_NULL;
    endfunction

    function automatic string word_text(lit_t s);
        string w;
        case (s)
            LIT_TRUE:  w = "true";
            LIT_FALSE: w = "false";
            default:   w = "null";
        endcase
        return w;
    endfunction

    // Byte seen between tokens.
    function automatic void open_token(logic [7:0] c);
        case (c)
            CH_SPACE, CH_NEWLINE: ;
            CH_LBRACE:   push_token(KIND_LBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_RBRACE:   push_token(KIND_RBRACE, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_LBRACKET: push_token(KIND_LBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_RBRACKET: push_token(KIND_RBRACKET, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_COMMA:    push_token(KIND_COMMA, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_COLON:    push_token(KIND_COLON, 8'd0, 1'b0, 1'b1, ERR_NONE);
            CH_QUOTE:    lex_mode = MODE_STRING;
            CH_N, CH_T, CH_F:
            begin
                if (c == CH_N)
                    lit_sel = LIT_NULL;
                else if (c == CH_T)
                    lit_sel = LIT_TRUE;
                else
                    lit_sel = LIT_FALSE;
                lit_pos  = 3'd1;
                lex_mode = MODE_LITERAL;
                push_token(word_kind(lit_sel), c, 1'b1, 1'b0, ERR_NONE);
            end
            default:
            begin
                if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE))
                begin
                    lex_mode = MODE_NUMBER;
                    push_token(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
                end
                else
                    lex_fail(ERR_START);
            end
        endcase
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eoi);
        string word;
        word = word_text(lit_sel);
        case (lex_mode)
            MODE_IDLE:
                if (!eoi)
                    open_token(c);
            MODE_STRING:
            begin
                if (eoi)
                    lex_fail(ERR_END);
                else if (c == CH_QUOTE)
                begin
                    lex_mode = MODE_IDLE;
                    push_token(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
                end
                else
                    push_token(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
            end
            MODE_NUMBER:
            begin
                if (!eoi && (c == CH_MINUS || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE)))
                    push_token(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
                else
                begin
                    // Close the number, then treat the byte as a fresh one.
                    lex_mode = MODE_IDLE;
                    push_token(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
                    if (!eoi)
                        open_token(c);
                end
            end
            MODE_LITERAL:
            begin
                if (eoi)
                    lex_fail(ERR_END);
                else if (lit_pos >= word.len() || c != word[lit_pos])
                    lex_fail(ERR_CHAR);
                else
                begin
                    lit_pos = lit_pos + 3'd1;
                    if (lit_pos >= word.len())
                    begin
                        lex_mode = MODE_IDLE;
                        lit_pos  = 3'd0;
                        push_token(word_kind(lit_sel), c, 1'b1, 1'b1, ERR_NONE);
                    end
                    else
                        push_token(word_kind(lit_sel), c, 1'b1, 1'b0, ERR_NONE);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_token();
        result_t want;
        result_t got;
        got.kind  = kind_t'(token_kind);
        got.value = value_byte;
        got.has   = has_byte;
        got.last  = token_end;
        got.err   = err_t'(error_code);
        checked++;
        if (token_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: token with nothing expected:", $time,
                         " kind=%0d value=%02h has=%0b end=%0b err=%0d",
                         got.kind, got.value, got.has, got.last, got.err);
            return;
        end
        want = token_q.pop_front();
        if (got.kind != want.kind || got.value != want.value || got.has != want.has ||
            got.last != want.last || got.err != want.err)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: token mismatch:", $time,
                         " expected kind=%0d value=%02h has=%0b end=%0b err=%0d,",
                         want.kind, want.value, want.has, want.last, want.err,
                         " got kind=%0d value=%02h has=%0b end=%0b err=%0d",
                         got.kind, got.value, got.has, got.last, got.err);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode = MODE_IDLE;
            lit_sel  = LIT_NULL;
            lit_pos  = 3'd0;
            token_q.delete();
            mismatches = 0;
            checked    = 0;
            fail_count     <= 0;
            pending        <= 0;
            tokens_checked <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                lex_byte(char_byte, end_of_input);
            if (token_valid && !token_stall)
                check_token();
            fail_count     <= mismatches;
            pending        <= token_q.size();
            tokens_checked <= checked;
        end
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jbl_pkg::*;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic [7:0] char_byte    = 8'd0;
    logic       end_of_input = 1'b0;
    logic       token_stall  = 1'b0;
    logic       byte_stall;
    logic       token_valid;
    logic [3:0] token_kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_end;
    logic [1:0] error_code;

    int fail_count;
    int pending;
    int tokens_checked;
    int sent_count = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    bit rx_hold    = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    json_byte_lexer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .value_byte   (value_byte),
        .has_byte     (has_byte),
        .token_end    (token_end),
        .error_code   (error_code)
    );

    json_lexer_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .char_byte      (char_byte),
        .end_of_input   (end_of_input),
        .token_valid    (token_valid),
        .token_stall    (token_stall),
        .token_kind     (token_kind),
        .value_byte     (value_byte),
        .has_byte       (has_byte),
        .token_end      (token_end),
        .error_code     (error_code),
        .fail_count     (fail_count),
        .pending        (pending),
        .tokens_checked (tokens_checked)
    );

    // Offer one byte request and hold it until accepted.
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid   <= 1'b1;
        char_byte    <= c;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (byte_stall);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_random_token();
        int         pick;
        int         n;
        logic [7:0] c;
        string      word;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            case ($urandom_range(0, 5))
                0:       c = CH_LBRACE;
                1:       c = CH_RBRACE;
                2:       c = CH_LBRACKET;
                3:       c = CH_RBRACKET;
                4:       c = CH_COMMA;
                default: c = CH_COLON;
            endcase
            send_byte(c, 1'b0);
        end
        else if (pick < 38)
            send_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE, 1'b0);
        else if (pick < 60)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            send_byte(CH_QUOTE, 1'b0);
            repeat (n)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_QUOTE)
                    c = c ^ 8'h01;
                send_byte(c, 1'b0);
            end
            send_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 82)
        begin
            c = ($urandom_range(0, 3) == 0) ? CH_MINUS : 8'(CH_ZERO + $urandom_range(0, 9));
            send_byte(c, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 11))
                    10:      c = CH_MINUS;
                    11:      c = CH_DOT;
                    default: c = 8'(CH_ZERO + $urandom_range(0, 9));
                endcase
                send_byte(c, 1'b0);
            end
        end
        else if (pick < 95)
        begin
            case ($urandom_range(0, 2))
                0:       word = "null";
                1:       word = "true";
                default: word = "false";
            endcase
            send_text(word);
        end
        else
            // end marker between tokens: ignored, or closes a pending number
            send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Errors stick until reset, so the stream ends with one of them.
    task automatic send_error_tail(output string what);
        string      word;
        int         cut;
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       word = "null";
            1:       word = "true";
            default: word = "false";
        endcase
        cut = $urandom_range(1, word.len() - 1);
        case ($urandom_range(0, 3))
            0:
            begin
                what = "a byte that starts no token";
                if ($urandom_range(0, 1))
                    c = 8'($urandom_range(8'h41, 8'h5A));
                else
                    c = 8'($urandom_range(8'h80, 8'hFF));
                send_byte(c, 1'b0);
            end
            1:
            begin
                what = "a wrong letter in a literal";
                send_text(word.substr(0, cut - 1));
                c = 8'($urandom_range(0, 255));
                if (c == word[cut])
                    c = c ^ 8'h01;
                send_byte(c, 1'b0);
            end
            2:
            begin
                what = "end of input inside a string";
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_byte(8'(CH_SPACE + $urandom_range(1, 1)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                what = "end of input inside a literal";
                send_text(word.substr(0, cut - 1));
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        // The lexer must stay silent from here on.
        repeat (8)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : token_sink
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (token_valid && !token_stall)
                wait_left = rx_quiet ? 0 : $urandom_range(0, 10);
            else if (wait_left > 0)
                wait_left--;
            @(negedge clk);
            token_stall <= rx_hold || (wait_left > 0);
        end
    end

    // Hold off the token side long enough for the byte side to back up.
    initial
    begin : long_hold
        wait (sent_count >= 600);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin : stimulus
        int    random_start;
        int    phase_left;
        int    mark;
        int    waited;
        bit    paused;
        string tail;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Punctuation, a string with extreme and newline bytes, numbers closed by
        // end of input and by a literal, end of input between tokens, whitespace.
        send_text("{}[],:");
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_text("-0.9");
        send_byte(8'h00, 1'b1);
        send_text("9null");
        send_byte(8'hFF, 1'b1);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);

        random_start = sent_count;
        phase_left   = 0;
        paused       = 1'b0;
        while (sent_count - random_start < 1650)
        begin
            if (phase_left <= 0)
            begin
                tx_quiet   = ($urandom_range(0, 3) == 0);
                rx_quiet   = ($urandom_range(0, 3) == 0);
                phase_left = 150;
                if (!paused && sent_count - random_start >= 1000)
                begin
                    // drop valid and let every expected token drain
                    @(negedge clk);
                    byte_valid <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                    paused = 1'b1;
                end
            end
            mark = sent_count;
            send_random_token();
            phase_left -= sent_count - mark;
        end

        send_error_tail(tail);
        @(negedge clk);
        byte_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d byte requests (%0d in random token streams)",
                 sent_count, sent_count - random_start,
                 " and checked %0d token results.", tokens_checked);
        $display("The stream ended with %s, followed by bytes in the error state.", tail);
        if (pending != 0)
            $display("%0d expected token results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
